FILE: sv/pcx_pkg.sv
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types and constants of the PCX run-length decoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LEN  = 1'b1;

  // Byte coding constants.
  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam int RUN_W = 6;
  localparam logic [RUN_W-1:0] RUN_ONE = 6'd1;

  // Command queue depth between front and back.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  // One classified input item: a byte, how many copies to emit, end of data.
  typedef struct packed {
    logic [7:0]       data;
    logic [RUN_W-1:0] copies;
    logic             eod;
  } cmd_t;

endpackage

FILE: sv/pcx_in_if.sv
// ----------------------------------------------------------------------------
// pcx_in_if
// Input channel: encoded bytes with an end-of-data marker.
// ----------------------------------------------------------------------------
interface pcx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_data;

  modport source (output valid, output in_byte, output end_of_data, input ready);
  modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

FILE: sv/pcx_out_if.sv
// ----------------------------------------------------------------------------
// pcx_out_if
// Result channel: decoded bytes with last and short-input flags.
// ----------------------------------------------------------------------------
interface pcx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       short_error;

  modport source (output valid, output out_byte, output last_byte, output short_error,
                  input ready);
  modport sink   (input valid, input out_byte, input last_byte, input short_error,
                  output ready);
endinterface

FILE: sv/pcx_front.sv
// ----------------------------------------------------------------------------
// pcx_front
// Accepts encoded bytes and classifies each into a copy command.
// ----------------------------------------------------------------------------
module pcx_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rle_enable,
  pcx_in_if.sink        in_ch,
  input  logic          fifo_full,
  output logic          push,
  output pcx_pkg::cmd_t push_cmd
);

  logic                      awaiting_r, awaiting_nxt;
  logic [pcx_pkg::RUN_W-1:0] run_r, run_nxt;
  logic                      is_count;

  assign in_ch.ready = !fifo_full;
  assign push        = in_ch.valid && !fifo_full;
  assign is_count    = rle_enable && ((in_ch.in_byte & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK);

  // Classify the byte: value of a pending run, a count byte, or a literal.
  always_comb begin
    awaiting_nxt      = awaiting_r;
    run_nxt           = run_r;
    push_cmd.data     = in_ch.in_byte;
    push_cmd.eod      = in_ch.end_of_data;
    push_cmd.copies   = pcx_pkg::RUN_ONE;
    if (awaiting_r) begin
      push_cmd.copies = run_r;
      awaiting_nxt    = 1'b0;
      run_nxt         = '0;
    end else if (is_count) begin
      push_cmd.copies = '0;
      awaiting_nxt    = 1'b1;
      run_nxt         = in_ch.in_byte[pcx_pkg::RUN_W-1:0];
    end
    if (in_ch.end_of_data) begin
      awaiting_nxt = 1'b0;
      run_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      run_r      <= '0;
    end else if (push) begin
      awaiting_r <= awaiting_nxt;
      run_r      <= run_nxt;
    end
  end

endmodule

FILE: sv/pcx_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pcx_cmd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pcx_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pcx_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pcx_pkg::cmd_t head_cmd
);

  pcx_pkg::cmd_t                  mem_r [pcx_pkg::FIFO_DEPTH];
  logic [pcx_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [pcx_pkg::FIFO_CNT_W-1:0] count_r;

  assign full       = (count_r == pcx_pkg::FIFO_CNT_W'(pcx_pkg::FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  // Storage; pushes are gated by full at the source.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: sv/pcx_back.sv
// ----------------------------------------------------------------------------
// pcx_back
// Expands copy commands into decoded bytes, tracks the decoded size and
// reports a short input at end of data.
// ----------------------------------------------------------------------------
module pcx_back #(
  parameter int SIZE_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [SIZE_WIDTH-1:0] image_len,
  input  logic                  head_valid,
  input  pcx_pkg::cmd_t         head_cmd,
  output logic                  pop,
  pcx_out_if.source             out_ch
);

  pcx_pkg::cmd_t             cur_r;
  logic                      cur_valid_r;
  logic [pcx_pkg::RUN_W-1:0] rem_r, rem_nxt;
  logic [SIZE_WIDTH-1:0]     produced_r, produced_nxt, produced_inc;
  logic                      done_r, done_nxt;
  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic                      out_last_r, out_err_r;

  logic       can_emit, active, done_now, hit, finish;
  logic       emit, emit_last, emit_err;
  logic [7:0] emit_byte;

  assign can_emit     = !out_valid_r || out_ch.ready;
  assign active       = cur_valid_r && can_emit;
  assign produced_inc = produced_r + 1'b1;
  assign done_now     = done_r || (produced_r >= image_len);
  assign hit          = (produced_inc == image_len);
  assign pop          = head_valid && (!cur_valid_r || finish);

  // One step of the current command per cycle, while the output register can take a byte.
  always_comb begin
    rem_nxt      = rem_r;
    produced_nxt = produced_r;
    done_nxt     = done_r;
    emit         = 1'b0;
    emit_byte    = cur_r.data;
    emit_last    = 1'b0;
    emit_err     = 1'b0;
    finish       = 1'b0;
    if (active) begin
      if (!done_now && (rem_r != '0)) begin
        emit         = 1'b1;
        emit_last    = hit;
        produced_nxt = produced_inc;
        rem_nxt      = rem_r - 1'b1;
        done_nxt     = hit;
        // An end of data that leaves the image short still owes an error result.
        if ((hit || (rem_r == pcx_pkg::RUN_ONE)) && (hit || !cur_r.eod)) begin
          finish = 1'b1;
          if (cur_r.eod) begin
            produced_nxt = '0;
            done_nxt     = 1'b0;
          end
        end
      end else begin
        finish = 1'b1;
        if (cur_r.eod) begin
          if (!done_now) begin
            emit      = 1'b1;
            emit_byte = '0;
            emit_last = 1'b1;
            emit_err  = 1'b1;
          end
          produced_nxt = '0;
          done_nxt     = 1'b0;
        end else begin
          done_nxt = done_now;
        end
      end
    end
  end

  // Current command and image progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      rem_r       <= '0;
      produced_r  <= '0;
      done_r      <= 1'b0;
    end else begin
      produced_r <= produced_nxt;
      done_r     <= done_nxt;
      if (pop) begin
        cur_valid_r <= 1'b1;
        rem_r       <= head_cmd.copies;
      end else begin
        rem_r <= rem_nxt;
        if (finish) begin
          cur_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_cmd;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
      out_err_r  <= emit_err;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_byte   = out_last_r;
  assign out_ch.short_error = out_err_r;

endmodule

FILE: sv/pcx_rle_decoder_top.sv
// ----------------------------------------------------------------------------
// pcx_rle_decoder_top
// PCX run-length decoder for image data after the header.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// in_ch     sink       in_byte, end_of_data
// out_ch    source     out_byte, last_byte, short_error
// cfg_*     input      write enable, register index, write data
//
// The back end emits a literal byte once and a run of n copies as n bytes, one
// output transfer per cycle while out_ch is ready, set by the single output
// register. A count byte or a byte after the image is done emits nothing; an
// error result emits one zero byte. The two-entry command queue lets input
// transfers continue while a run is emitted, then back-pressures the input.
// Reset is synchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module pcx_rle_decoder_top #(
  parameter int SIZE_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pcx_in_if.sink                        in_ch,
  pcx_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [pcx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_WIDTH-1:0]         cfg_data
);

  logic                  rle_enable_r;
  logic [SIZE_WIDTH-1:0] image_len_r;
  logic                  push, fifo_full, pop, head_valid;
  pcx_pkg::cmd_t         push_cmd, head_cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_enable_r <= 1'b1;
      image_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcx_pkg::CFG_RLE_ENABLE: rle_enable_r <= cfg_data[0];
        pcx_pkg::CFG_IMAGE_LEN:  image_len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  pcx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .rle_enable (rle_enable_r),
    .in_ch      (in_ch),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  pcx_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pcx_back #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .image_len  (image_len_r),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
